// File: sv/sbt_pkg.sv
// shared types, token codes and keyword table of the sql byte tokenizer
package sbt_pkg;

   // field widths of the items
   localparam int OUT_POS_W     = 16;
   localparam int MAX_RESULTS   = 4;
   localparam int RES_CNT_W     = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH   = 2;
   localparam int KW_COUNT      = 55;
   localparam int KW_CHARS      = 8;

   // parameter defaults
   localparam int DEF_POS_BITS        = 16;
   localparam int DEF_KEYWORD_MAX_LEN = 8;

   // token kinds
   localparam logic [6:0] TK_IDENT  = 7'd0;
   localparam logic [6:0] TK_INT    = 7'd1;
   localparam logic [6:0] TK_STR    = 7'd2;
   localparam logic [6:0] TK_COMMA  = 7'd3;
   localparam logic [6:0] TK_DOT    = 7'd4;
   localparam logic [6:0] TK_LPAREN = 7'd5;
   localparam logic [6:0] TK_RPAREN = 7'd6;
   localparam logic [6:0] TK_STAR   = 7'd7;
   localparam logic [6:0] TK_EQ     = 7'd8;
   localparam logic [6:0] TK_NE     = 7'd9;
   localparam logic [6:0] TK_GT     = 7'd10;
   localparam logic [6:0] TK_GE     = 7'd11;
   localparam logic [6:0] TK_LT     = 7'd12;
   localparam logic [6:0] TK_LE     = 7'd13;
   localparam logic [6:0] TK_PLUS   = 7'd14;
   localparam logic [6:0] TK_MINUS  = 7'd15;
   localparam logic [6:0] TK_SLASH  = 7'd16;
   localparam logic [6:0] TK_SEMI   = 7'd17;
   localparam logic [6:0] TK_KW0    = 7'd18;
   localparam logic [6:0] TK_EOF    = 7'd73;

   // error kinds
   localparam logic [2:0] ER_NONE         = 3'd0;
   localparam logic [2:0] ER_OPEN_COMMENT = 3'd1;
   localparam logic [2:0] ER_BAD_NUMBER   = 3'd2;
   localparam logic [2:0] ER_OPEN_STRING  = 3'd3;
   localparam logic [2:0] ER_ILLEGAL      = 3'd4;

   // scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE, MODE_MINUS, MODE_SLASH, MODE_OP, MODE_WORD, MODE_NUM,
      MODE_NUMDOT, MODE_BADNUM, MODE_LCOM, MODE_BCOM, MODE_BSTAR,
      MODE_STR, MODE_SQUOTE
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       byte_valid;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [6:0]           token_kind;
      logic [2:0]           error_kind;
      logic [OUT_POS_W-1:0] start_offset;
      logic [OUT_POS_W-1:0] stop_offset;
      logic [OUT_POS_W-1:0] first_line;
      logic [OUT_POS_W-1:0] first_column;
      logic [OUT_POS_W-1:0] stop_line;
      logic [OUT_POS_W-1:0] stop_column;
      logic                 is_last;
   } rsp_type;

   // all items caused by one input item, in order
   typedef struct packed {
      logic [RES_CNT_W-1:0]         count;
      rsp_type [MAX_RESULTS-1:0]    items;
   } bundle_type;

   // keywords, first character in the top byte, zero padded
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      {"create", 16'h0}, {"table", 24'h0}, {"index", 24'h0}, {"unique", 16'h0},
      {"on", 48'h0}, {"insert", 16'h0}, {"into", 32'h0}, {"values", 16'h0},
      {"select", 16'h0}, {"explain", 8'h0}, "distinct", {"from", 32'h0},
      {"where", 24'h0}, {"is", 48'h0}, {"between", 8'h0}, {"in", 48'h0},
      {"like", 32'h0}, {"group", 24'h0}, {"having", 16'h0}, {"order", 24'h0},
      {"by", 48'h0}, {"limit", 24'h0}, {"asc", 40'h0}, {"desc", 32'h0},
      {"as", 48'h0}, {"exists", 16'h0}, {"join", 32'h0}, {"inner", 24'h0},
      {"left", 32'h0}, {"right", 24'h0}, {"full", 32'h0}, {"outer", 24'h0},
      {"delete", 16'h0}, {"drop", 32'h0}, {"alter", 24'h0}, {"add", 40'h0},
      {"column", 16'h0}, {"rename", 16'h0}, {"to", 48'h0}, {"default", 8'h0},
      {"primary", 8'h0}, {"key", 40'h0}, {"begin", 24'h0}, {"commit", 16'h0},
      "rollback", {"update", 16'h0}, {"set", 40'h0}, {"int", 40'h0},
      {"varchar", 8'h0}, {"and", 40'h0}, {"or", 48'h0}, {"not", 40'h0},
      {"true", 32'h0}, {"false", 24'h0}, {"null", 32'h0}
   };

   // keyword match of a folded word, byte j of the word at [8j +: 8]
   function automatic logic [6:0] kw_kind(input logic [63:0] word, input logic [4:0] len);
      logic [6:0] kind;
      logic       found;
      logic       ok;
      logic [4:0] klen;
      kind  = TK_IDENT;
      found = 1'b0;
      for (int i = 0; i < KW_COUNT; i++) begin
         klen = '0;
         for (int j = 0; j < KW_CHARS; j++) begin
            if (KW_TEXT[i][63-8*j -: 8] != 8'h0) klen = klen + 5'd1;
         end
         ok = (klen == len);
         for (int j = 0; j < KW_CHARS; j++) begin
            if (5'(j) < len && KW_TEXT[i][63-8*j -: 8] != word[8*j +: 8]) ok = 1'b0;
         end
         if (ok && !found) begin
            kind  = TK_KW0 + 7'(i);
            found = 1'b1;
         end
      end
      return kind;
   endfunction

endpackage

// File: sv/sbt_front.sv
// scanner front end: takes bytes, tracks position, builds the items of each byte
module sbt_front
   import sbt_pkg::*;
#(
   parameter int POS_BITS        = DEF_POS_BITS,
   parameter int KEYWORD_MAX_LEN = DEF_KEYWORD_MAX_LEN
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_item,
   input  logic       q_full,
   output logic       push,
   output bundle_type push_data
);

   localparam int PW   = POS_BITS;
   localparam int KML  = KEYWORD_MAX_LEN;
   localparam int LENW = $clog2(KML + 2);
   localparam int IDXW = $clog2(KML);

   typedef struct packed {
      logic [PW-1:0] off;
      logic [PW-1:0] line;
      logic [PW-1:0] col;
   } spot_type;

   localparam spot_type SPOT_HOME = '{off: '0, line: PW'(1), col: PW'(1)};

   function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
      return (v == {PW{1'b1}}) ? v : v + PW'(1);
   endfunction

   function automatic spot_type step_pos(input spot_type s, input logic [7:0] c);
      spot_type r;
      r     = s;
      r.off = sat_inc(s.off);
      if (c == "\n") begin
         r.line = sat_inc(s.line);
         r.col  = PW'(1);
      end else begin
         r.col = sat_inc(s.col);
      end
      return r;
   endfunction

   function automatic rsp_type mk(input logic [6:0] kind, input logic [2:0] err,
                                  input spot_type a, input spot_type e, input logic last);
      rsp_type r;
      r.token_kind   = kind;
      r.error_kind   = err;
      r.start_offset = OUT_POS_W'(a.off);
      r.stop_offset  = OUT_POS_W'(e.off);
      r.first_line   = OUT_POS_W'(a.line);
      r.first_column = OUT_POS_W'(a.col);
      r.stop_line    = OUT_POS_W'(e.line);
      r.stop_column  = OUT_POS_W'(e.col);
      r.is_last      = last;
      return r;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [7:0] fold(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic [6:0] single_op(input logic [7:0] c);
      if (c == "<") return TK_LT;
      if (c == ">") return TK_GT;
      if (c == "!") return TK_NE;
      return TK_EQ;
   endfunction

   function automatic logic [6:0] pair_op(input logic [7:0] c);
      if (c == "<") return TK_LE;
      if (c == ">") return TK_GE;
      if (c == "!") return TK_NE;
      return TK_EQ;
   endfunction

   // scanner state
   mode_type      mode_ff, mode_in;
   logic [7:0]    wbuf_ff [KML];
   logic [7:0]    wbuf_in [KML];
   logic [LENW-1:0] wlen_ff, wlen_in;
   logic [7:0]    held_ff, held_in;
   spot_type      pos_ff, pos_in;
   spot_type      tok_ff, tok_in;
   spot_type      dot_ff, dot_in;
   logic          err_ff, err_in;

   logic          accept;
   logic [7:0]    b;
   logic          fed;
   logic          eot;
   logic          again;
   logic          flush_err;
   spot_type      p;
   spot_type      pa;
   logic          word_new;
   logic          word_grow;
   logic          word_done;
   logic [63:0]   word_cur;
   logic [63:0]   word_nxt;
   logic [63:0]   word_sel;
   logic [LENW-1:0] len_sel;
   logic [6:0]    wk;
   logic [6:0]    punct;
   rsp_type       cand [6];
   logic [5:0]    cv;
   logic [RES_CNT_W-1:0] fill;

   assign accept    = req_valid && req_ready;
   assign req_ready = !q_full;
   assign b         = req_item.in_byte;
   assign eot       = req_item.end_of_text;
   assign fed       = req_item.byte_valid && !err_ff;
   assign p         = pos_ff;
   assign pa        = step_pos(pos_ff, b);

   // word buffer update: a new word or one more character
   assign word_new  = fed && (is_alpha(b) || b == "_") &&
                      mode_ff != MODE_WORD && mode_ff != MODE_BADNUM &&
                      mode_ff != MODE_LCOM && mode_ff != MODE_BCOM &&
                      mode_ff != MODE_BSTAR && mode_ff != MODE_STR;
   assign word_grow = fed && mode_ff == MODE_WORD && (is_alpha(b) || is_digit(b) || b == "_");
   assign word_done = fed && mode_ff == MODE_WORD && !(is_alpha(b) || is_digit(b) || b == "_");

   always_comb begin
      wbuf_in = wbuf_ff;
      wlen_in = wlen_ff;
      if (word_new) begin
         wbuf_in[0] = fold(b);
         wlen_in    = LENW'(1);
      end else if (word_grow) begin
         if (wlen_ff < LENW'(KML)) wbuf_in[wlen_ff[IDXW-1:0]] = fold(b);
         if (wlen_ff <= LENW'(KML)) wlen_in = wlen_ff + LENW'(1);
      end
   end

   // keyword lookup on the finished word
   always_comb begin
      for (int j = 0; j < KW_CHARS; j++) begin
         word_cur[8*j +: 8] = wbuf_ff[j];
         word_nxt[8*j +: 8] = wbuf_in[j];
      end
   end

   assign word_sel = word_done ? word_cur : word_nxt;
   assign len_sel  = word_done ? wlen_ff : wlen_in;
   assign wk       = (len_sel > LENW'(KML)) ? TK_IDENT : kw_kind(word_sel, 5'(len_sel));

   // one-byte punctuation
   always_comb begin
      case (b)
         ",":     punct = TK_COMMA;
         ".":     punct = TK_DOT;
         "(":     punct = TK_LPAREN;
         ")":     punct = TK_RPAREN;
         "*":     punct = TK_STAR;
         "+":     punct = TK_PLUS;
         ";":     punct = TK_SEMI;
         default: punct = TK_IDENT;
      endcase
   end

   // scan step: close the open lexeme, start a new one, then end of text
   always_comb begin
      mode_in   = mode_ff;
      held_in   = held_ff;
      pos_in    = pos_ff;
      tok_in    = tok_ff;
      dot_in    = dot_ff;
      err_in    = err_ff;
      again     = 1'b0;
      flush_err = 1'b0;
      cv        = '0;
      for (int i = 0; i < 6; i++) cand[i] = '0;

      if (fed) begin
         unique case (mode_ff)
            MODE_MINUS: begin
               if (b == "-") mode_in = MODE_LCOM;
               else if (is_digit(b)) mode_in = MODE_NUM;
               else begin
                  cand[0] = mk(TK_MINUS, ER_NONE, tok_ff, p, 1'b0);
                  cv[0]   = 1'b1;
                  again   = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (b == "*") mode_in = MODE_BCOM;
               else begin
                  cand[0] = mk(TK_SLASH, ER_NONE, tok_ff, p, 1'b0);
                  cv[0]   = 1'b1;
                  again   = 1'b1;
               end
            end
            MODE_OP: begin
               if (b == "=") begin
                  cand[0] = mk(pair_op(held_ff), ER_NONE, tok_ff, pa, 1'b0);
                  cv[0]   = 1'b1;
                  mode_in = MODE_IDLE;
               end else if (held_ff == "<" && b == ">") begin
                  cand[0] = mk(TK_NE, ER_NONE, tok_ff, pa, 1'b0);
                  cv[0]   = 1'b1;
                  mode_in = MODE_IDLE;
               end else begin
                  cand[0] = mk(single_op(held_ff), ER_NONE, tok_ff, p, 1'b0);
                  cv[0]   = 1'b1;
                  again   = 1'b1;
               end
            end
            MODE_WORD: begin
               if (word_done) begin
                  cand[0] = mk(wk, ER_NONE, tok_ff, p, 1'b0);
                  cv[0]   = 1'b1;
                  again   = 1'b1;
               end
            end
            MODE_NUM: begin
               if (b == ".") begin
                  dot_in  = p;
                  mode_in = MODE_NUMDOT;
               end else if (!is_digit(b)) begin
                  cand[0] = mk(TK_INT, ER_NONE, tok_ff, p, 1'b0);
                  cv[0]   = 1'b1;
                  again   = 1'b1;
               end
            end
            MODE_NUMDOT: begin
               if (is_digit(b)) mode_in = MODE_BADNUM;
               else begin
                  cand[0] = mk(TK_INT, ER_NONE, tok_ff, dot_ff, 1'b0);
                  cand[1] = mk(TK_DOT, ER_NONE, dot_ff, p, 1'b0);
                  cv[1:0] = 2'b11;
                  again   = 1'b1;
               end
            end
            MODE_BADNUM: begin
               if (!is_digit(b) && b != ".") begin
                  cand[0] = mk(TK_IDENT, ER_BAD_NUMBER, tok_ff, p, 1'b1);
                  cv[0]   = 1'b1;
                  err_in  = 1'b1;
               end
            end
            MODE_LCOM: begin
               if (b == "\n" || b == "\r") mode_in = MODE_IDLE;
            end
            MODE_BCOM: begin
               if (b == "*") mode_in = MODE_BSTAR;
            end
            MODE_BSTAR: begin
               if (b == "/") mode_in = MODE_IDLE;
               else if (b != "*") mode_in = MODE_BCOM;
            end
            MODE_STR: begin
               if (b == "'") mode_in = MODE_SQUOTE;
            end
            MODE_SQUOTE: begin
               if (b == "'") mode_in = MODE_STR;
               else begin
                  cand[0] = mk(TK_STR, ER_NONE, tok_ff, p, 1'b0);
                  cv[0]   = 1'b1;
                  again   = 1'b1;
               end
            end
            default: ;
         endcase

         // start of a new lexeme
         if (mode_ff == MODE_IDLE || again || mode_ff > MODE_SQUOTE) begin
            mode_in = MODE_IDLE;
            if (!is_space(b)) begin
               tok_in = p;
               if (b == "-") mode_in = MODE_MINUS;
               else if (b == "/") mode_in = MODE_SLASH;
               else if (b == "<" || b == ">" || b == "!" || b == "=") begin
                  held_in = b;
                  mode_in = MODE_OP;
               end else if (is_alpha(b) || b == "_") mode_in = MODE_WORD;
               else if (is_digit(b)) mode_in = MODE_NUM;
               else if (b == "'") mode_in = MODE_STR;
               else if (punct != TK_IDENT) begin
                  cand[2] = mk(punct, ER_NONE, p, pa, 1'b0);
                  cv[2]   = 1'b1;
               end else begin
                  cand[2] = mk(TK_IDENT, ER_ILLEGAL, p, pa, 1'b1);
                  cv[2]   = 1'b1;
                  err_in  = 1'b1;
               end
            end
         end
         pos_in = pa;
      end

      // end of text closes the open lexeme and adds the eof item, unless the scan ends in an error
      if (eot && !err_in) begin
         unique case (mode_in)
            MODE_MINUS: begin
               cand[3] = mk(TK_MINUS, ER_NONE, tok_in, pos_in, 1'b0);
               cv[3]   = 1'b1;
            end
            MODE_SLASH: begin
               cand[3] = mk(TK_SLASH, ER_NONE, tok_in, pos_in, 1'b0);
               cv[3]   = 1'b1;
            end
            MODE_OP: begin
               cand[3] = mk(single_op(held_in), ER_NONE, tok_in, pos_in, 1'b0);
               cv[3]   = 1'b1;
            end
            MODE_WORD: begin
               cand[3] = mk(wk, ER_NONE, tok_in, pos_in, 1'b0);
               cv[3]   = 1'b1;
            end
            MODE_NUM: begin
               cand[3] = mk(TK_INT, ER_NONE, tok_in, pos_in, 1'b0);
               cv[3]   = 1'b1;
            end
            MODE_NUMDOT: begin
               cand[3] = mk(TK_INT, ER_NONE, tok_in, dot_in, 1'b0);
               cand[4] = mk(TK_DOT, ER_NONE, dot_in, pos_in, 1'b0);
               cv[4:3] = 2'b11;
            end
            MODE_BADNUM: begin
               cand[3]   = mk(TK_IDENT, ER_BAD_NUMBER, tok_in, pos_in, 1'b1);
               cv[3]     = 1'b1;
               flush_err = 1'b1;
            end
            MODE_BCOM, MODE_BSTAR: begin
               cand[3]   = mk(TK_IDENT, ER_OPEN_COMMENT, tok_in, pos_in, 1'b1);
               cv[3]     = 1'b1;
               flush_err = 1'b1;
            end
            MODE_STR: begin
               cand[3]   = mk(TK_IDENT, ER_OPEN_STRING, tok_in, pos_in, 1'b1);
               cv[3]     = 1'b1;
               flush_err = 1'b1;
            end
            MODE_SQUOTE: begin
               cand[3] = mk(TK_STR, ER_NONE, tok_in, pos_in, 1'b0);
               cv[3]   = 1'b1;
            end
            default: ;
         endcase
         if (!flush_err) begin
            cand[5] = mk(TK_EOF, ER_NONE, pos_in, pos_in, 1'b1);
            cv[5]   = 1'b1;
         end
      end
   end

   // pack the produced items in order
   always_comb begin
      push_data = '0;
      fill      = '0;
      for (int i = 0; i < 6; i++) begin
         if (cv[i] && fill < RES_CNT_W'(MAX_RESULTS)) begin
            push_data.items[fill[1:0]] = cand[i];
            fill = fill + RES_CNT_W'(1);
         end
      end
      push_data.count = fill;
   end

   assign push = accept && (fill != '0);

   // scanner registers, back to home position at end of text
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         wlen_ff <= '0;
         held_ff <= '0;
         pos_ff  <= SPOT_HOME;
         tok_ff  <= SPOT_HOME;
         dot_ff  <= SPOT_HOME;
         err_ff  <= 1'b0;
      end else if (accept) begin
         if (eot) begin
            mode_ff <= MODE_IDLE;
            wlen_ff <= '0;
            held_ff <= '0;
            pos_ff  <= SPOT_HOME;
            tok_ff  <= SPOT_HOME;
            dot_ff  <= SPOT_HOME;
            err_ff  <= 1'b0;
         end else begin
            mode_ff <= mode_in;
            wlen_ff <= wlen_in;
            held_ff <= held_in;
            pos_ff  <= pos_in;
            tok_ff  <= tok_in;
            dot_ff  <= dot_in;
            err_ff  <= err_in;
         end
      end
   end

   // word characters
   always_ff @(posedge clock) begin
      if (accept) wbuf_ff <= wbuf_in;
   end

endmodule

// File: sv/sbt_queue.sv
// short queue of item bundles between the scanner and the output stage
module sbt_queue
   import sbt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   input  logic       pop,
   output bundle_type head,
   output logic       empty,
   output logic       full
);

   localparam int PTRW = $clog2(QUEUE_DEPTH);
   localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

   bundle_type       mem_ff [QUEUE_DEPTH];
   logic [PTRW-1:0]  wr_ff, wr_in;
   logic [PTRW-1:0]  rd_ff, rd_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNTW'(QUEUE_DEPTH));
   assign head  = mem_ff[rd_ff];

   // pointer and fill level
   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == PTRW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTRW'(1);
      if (pop)  rd_in = (rd_ff == PTRW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTRW'(1);
      if (push && !pop) count_in = count_ff + CNTW'(1);
      else if (pop && !push) count_in = count_ff - CNTW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("bundle pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("bundle popped from an empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(QUEUE_DEPTH))
      else $error("queue fill level out of range");

endmodule

// File: sv/sbt_back.sv
// output stage: walks each bundle and presents one item per cycle while the queue holds a bundle and rsp_ready is high
module sbt_back
   import sbt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  bundle_type head,
   input  logic       q_empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_item
);

   logic                 out_valid_ff;
   rsp_type              out_item_ff;
   logic [1:0]           idx_ff;
   logic                 load;
   logic                 last_of;

   // load the next item whenever the output register is free or being taken
   assign load    = !q_empty && (!out_valid_ff || rsp_ready);
   assign last_of = (RES_CNT_W'(idx_ff) + RES_CNT_W'(1)) == head.count;
   assign pop     = load && last_of;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
         if (load) idx_ff <= last_of ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) out_item_ff <= head.items[idx_ff];
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   a_idx_in_bundle: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> RES_CNT_W'(idx_ff) < head.count)
      else $error("item index past the end of its bundle");
   a_bundle_not_empty: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> head.count != '0)
      else $error("empty bundle in the queue");
   a_idx_rewinds: assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0)
      else $error("item index not rewound after a bundle");

endmodule

// File: sv/sql_byte_tokenizer.sv
// top level of the sql byte tokenizer
//
// One statement enters as a stream of byte items on req_ (in_byte, byte_valid,
// end_of_text) and leaves as token items on rsp_: kind, error code, start and
// end offset, line and column, and is_last on the eof or error item.
// An item with byte_valid low and end_of_text low does nothing; every item
// with end_of_text high closes the statement and homes offset, line, column.
// Items caused by an accepted byte pass through the bundle queue and the output
// register to rsp_, one per cycle in order while rsp_ready is high.
// Throughput: one byte per cycle while each byte gives at most one item and
// rsp_ready stays high; the output stage sends one item per cycle, so the items
// of a byte that gives more than one item are absorbed by the two-bundle queue
// before req_ready drops.
// Reset clears the scanner, the queue and the output register; req_ready is
// high once the queue has been cleared.
// When the receiver stalls the result holds on rsp_, the queue fills, and
// req_ready drops once both queue entries are taken.
module sql_byte_tokenizer
   import sbt_pkg::*;
#(
   parameter int POS_BITS        = DEF_POS_BITS,
   parameter int KEYWORD_MAX_LEN = DEF_KEYWORD_MAX_LEN
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   logic       push;
   logic       pop;
   logic       q_empty;
   logic       q_full;
   bundle_type push_data;
   bundle_type head;

   // scanner
   sbt_front #(
      .POS_BITS        (POS_BITS),
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   // bundle queue
   sbt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // output stage
   sbt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
